// File: rtl/fr_pkg.sv
package fr_pkg;

    localparam int FR_VEC_FRAC_BITS = 14;
    localparam int FR_IOR_FRAC_BITS = 12;
    localparam int FR_WF            = 30;
    localparam int FR_CW            = FR_WF + 1;

    localparam logic [FR_CW-1:0] FR_WONE    = FR_CW'(1) << FR_WF;
    localparam logic [15:0]      FR_IOR_ONE = 16'd4096;
    localparam logic [15:0]      FR_OUT_ONE = 16'd32768;

    // amplitude ratio operands are brought below this many bits
    localparam int FR_DEN_BITS = 33;
    localparam int FR_PROD_W   = 48;
    localparam int FR_SH_W     = 4;

    typedef struct packed {
        logic signed [15:0] incident_x;
        logic signed [15:0] incident_y;
        logic signed [15:0] incident_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [15:0]        refr_index;
    } t_fr_in;

    typedef struct packed {
        logic [15:0] reflectance;
        logic        total_reflection;
    } t_fr_out;

    // right shift that brings den below 2^FR_DEN_BITS
    function automatic logic [FR_SH_W-1:0] fr_norm_shift(input logic [FR_PROD_W-1:0] den);
        logic [FR_SH_W-1:0] sh;
        sh = '0;
        for (int i = 0; i < FR_PROD_W - FR_DEN_BITS; i++) begin
            if (den[FR_DEN_BITS + i]) begin
                sh = FR_SH_W'(i + 1);
            end
        end
        return sh;
    endfunction

endpackage

// File: rtl/fr_sqrt_pipe.sv
module fr_sqrt_pipe #(
    parameter int RW = 31,
    parameter int SW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*RW-1:0]   i_rad,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [RW-1:0]     o_root,
    output logic [SW-1:0]     o_side
);

    logic              r_v    [RW];
    logic [2*RW-1:0]   r_rad  [RW];
    logic [RW:0]       r_rem  [RW];
    logic [RW-1:0]     r_root [RW];
    logic [SW-1:0]     r_side [RW];

    // one root bit per stage
    for (genvar k = 0; k < RW; k++) begin : g_st
        logic            p_v;
        logic [2*RW-1:0] p_rad;
        logic [RW:0]     p_rem;
        logic [RW-1:0]   p_root;
        logic [SW-1:0]   p_side;
        logic [RW+2:0]   rem_sh;
        logic [RW+2:0]   trial;
        logic [RW+2:0]   diff;
        logic            ge;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rad  = i_rad;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_side = r_side[k-1];
        end

        assign rem_sh = {p_rem, p_rad[2*RW-1 -: 2]};
        assign trial  = {1'b0, p_root, 2'b01};
        assign diff   = rem_sh - trial;
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= {p_rad[2*RW-3:0], 2'b00};
                r_rem[k]  <= ge ? diff[RW:0] : rem_sh[RW:0];
                r_root[k] <= {p_root[RW-2:0], ge};
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

// File: rtl/fr_div_pipe.sv
module fr_div_pipe #(
    parameter int DW = 16,
    parameter int QW = 43,
    parameter int SW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DW-1:0]     i_hi,
    input  logic [QW-1:0]     i_lo,
    input  logic [DW-1:0]     i_den,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [QW-1:0]     o_quot,
    output logic [SW-1:0]     o_side
);

    // i_hi must be below i_den; the quotient then fits QW bits
    logic              r_v    [QW];
    logic [DW-1:0]     r_rem  [QW];
    logic [QW-1:0]     r_lo   [QW];
    logic [DW-1:0]     r_den  [QW];
    logic [SW-1:0]     r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_st
        logic          p_v;
        logic [DW-1:0] p_rem;
        logic [QW-1:0] p_lo;
        logic [DW-1:0] p_den;
        logic [SW-1:0] p_side;
        logic [DW:0]   rem_sh;
        logic [DW:0]   diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rem  = i_hi;
            assign p_lo   = i_lo;
            assign p_den  = i_den;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_lo   = r_lo[k-1];
            assign p_den  = r_den[k-1];
            assign p_side = r_side[k-1];
        end

        assign rem_sh = {p_rem, p_lo[QW-1]};
        assign ge     = rem_sh >= {1'b0, p_den};
        assign diff   = rem_sh - {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        // shift quotient bits in where dividend bits leave
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
                r_lo[k]   <= {p_lo[QW-2:0], ge};
                r_den[k]  <= p_den;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quot  = r_lo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// File: rtl/fresnel_reflectance.sv
// Unpolarized dielectric Fresnel reflectance, fully pipelined.
// Input channel: i_valid / o_stall carrying i_data (incident vector, normal
// vector, index of refraction). A beat is taken on a rising edge with
// i_valid high and o_stall low.
// Output channel: o_valid / i_stall carrying o_data (reflectance in Q1.15
// and the total internal reflection flag). A beat leaves on a rising edge
// with o_valid high and i_stall low.
// One beat per cycle while the output is not stalled. The pipeline has
// 148 register stages: the two 31-stage square roots, the 43-stage
// divider for sin(theta_t) and the 31-stage amplitude ratio dividers,
// each retiring one bit per stage, plus the multiply stages around them.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall is raised; nothing is dropped or repeated.
// Reset (synchronous, active low) clears every stage valid bit; the first
// beat may be offered in the cycle after reset is released.
module fresnel_reflectance #(
    parameter int VEC_FRAC_BITS = fr_pkg::FR_VEC_FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  fr_pkg::t_fr_in  i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output fr_pkg::t_fr_out o_data
);

    import fr_pkg::*;

    localparam logic signed [63:0] LIM = 64'sd1 <<< (2 * VEC_FRAC_BITS);
    localparam int DSH = 2 * VEC_FRAC_BITS - FR_WF;
    localparam int SIDE1_W = 1 + FR_CW + 16;
    localparam int SIDE2_W = SIDE1_W + FR_CW;
    localparam int SIDE3_W = 1 + SIDE1_W;

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // stage 1: component products
    logic               r1_v;
    logic signed [31:0] r1_p0, r1_p1, r1_p2;
    logic [15:0]        r1_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p0 <= i_data.incident_x * i_data.normal_x;
            r1_p1 <= i_data.incident_y * i_data.normal_y;
            r1_p2 <= i_data.incident_z * i_data.normal_z;
            r1_n  <= (i_data.refr_index == 16'd0) ? 16'd1 : i_data.refr_index;
        end
    end

    // stage 2: dot product, clamp, orientation, cosine in Q30
    logic signed [63:0] dot, dot_cl;
    logic [63:0]        d_abs;
    logic [FR_CW-1:0]   n2_c;
    logic               n2_leave;

    assign dot = $signed({{32{r1_p0[31]}}, r1_p0}) + $signed({{32{r1_p1[31]}}, r1_p1})
               + $signed({{32{r1_p2[31]}}, r1_p2});

    always_comb begin
        if (dot > LIM) begin
            dot_cl = LIM;
        end else if (dot < -LIM) begin
            dot_cl = -LIM;
        end else begin
            dot_cl = dot;
        end
    end

    assign n2_leave = dot_cl[63];
    assign d_abs    = n2_leave ? 64'(-dot_cl) : 64'(dot_cl);

    if (DSH >= 0) begin : g_shr
        assign n2_c = d_abs[DSH +: FR_CW];
    end else begin : g_shl
        logic [63:0] d_sh;
        assign d_sh = d_abs << (-DSH);
        assign n2_c = d_sh[FR_CW-1:0];
    end

    logic             r2_v, r2_leave;
    logic [FR_CW-1:0] r2_c;
    logic [15:0]      r2_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_c     <= n2_c;
            r2_leave <= n2_leave;
            r2_n     <= r1_n;
        end
    end

    // stage 3: cos^2
    logic [2*FR_CW-1:0] csq_full;
    assign csq_full = (2*FR_CW)'(r2_c) * (2*FR_CW)'(r2_c);

    logic             r3_v, r3_leave;
    logic [FR_CW-1:0] r3_c, r3_csq;
    logic [15:0]      r3_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_csq   <= csq_full[FR_WF +: FR_CW];
            r3_c     <= r2_c;
            r3_leave <= r2_leave;
            r3_n     <= r2_n;
        end
    end

    // sin(theta_i)
    logic               sq1_v;
    logic [FR_CW-1:0]   si;
    logic [SIDE1_W-1:0] sq1_side;
    logic               s1_leave;
    logic [FR_CW-1:0]   s1_c;
    logic [15:0]        s1_n;

    fr_sqrt_pipe #(.RW(FR_CW), .SW(SIDE1_W)) u_sqrt_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_v),
        .i_rad   ({1'b0, FR_WONE - r3_csq, FR_WF'(0)}),
        .i_side  ({r3_leave, r3_c, r3_n}),
        .o_valid (sq1_v),
        .o_root  (si),
        .o_side  (sq1_side)
    );

    assign {s1_leave, s1_c, s1_n} = sq1_side;

    // sin(theta_t) on entry: si * 1.0 / n
    localparam int QW1 = FR_CW + FR_IOR_FRAC_BITS;

    logic               dv1_v;
    logic [QW1-1:0]     st_ent;
    logic [SIDE2_W-1:0] dv1_side;
    logic               s2_leave;
    logic [FR_CW-1:0]   s2_c, s2_si;
    logic [15:0]        s2_n;

    fr_div_pipe #(.DW(16), .QW(QW1), .SW(SIDE2_W)) u_div_sint (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq1_v),
        .i_hi    (16'd0),
        .i_lo    ({si, FR_IOR_FRAC_BITS'(0)}),
        .i_den   (s1_n),
        .i_side  ({sq1_side, si}),
        .o_valid (dv1_v),
        .o_quot  (st_ent),
        .o_side  (dv1_side)
    );

    assign {s2_leave, s2_c, s2_n, s2_si} = dv1_side;

    // stage 5: pick sin(theta_t), detect total internal reflection
    logic [FR_CW+15:0] st_lv_full;
    logic [QW1-1:0]    n5_st;

    assign st_lv_full = (FR_CW+16)'(s2_si) * (FR_CW+16)'(s2_n);
    assign n5_st      = s2_leave ? QW1'(st_lv_full[FR_CW+15:FR_IOR_FRAC_BITS]) : st_ent;

    logic             r5_v, r5_tir, r5_leave;
    logic [FR_CW-1:0] r5_st, r5_c;
    logic [15:0]      r5_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= dv1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_st    <= n5_st[FR_CW-1:0];
            r5_tir   <= n5_st >= QW1'(FR_WONE);
            r5_leave <= s2_leave;
            r5_c     <= s2_c;
            r5_n     <= s2_n;
        end
    end

    // stage 6: sin_t^2 (meaningless under total reflection, masked later)
    logic [2*FR_CW-1:0] ssq_full;
    assign ssq_full = (2*FR_CW)'(r5_st) * (2*FR_CW)'(r5_st);

    logic             r6_v, r6_tir, r6_leave;
    logic [FR_CW-1:0] r6_ssq, r6_c;
    logic [15:0]      r6_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_ssq   <= ssq_full[FR_WF +: FR_CW];
            r6_tir   <= r5_tir;
            r6_leave <= r5_leave;
            r6_c     <= r5_c;
            r6_n     <= r5_n;
        end
    end

    // cos(theta_t)
    logic               sq2_v;
    logic [FR_CW-1:0]   ct;
    logic [SIDE3_W-1:0] sq2_side;
    logic               s3_tir, s3_leave;
    logic [FR_CW-1:0]   s3_c;
    logic [15:0]        s3_n;

    fr_sqrt_pipe #(.RW(FR_CW), .SW(SIDE3_W)) u_sqrt_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_v),
        .i_rad   ({1'b0, FR_WONE - r6_ssq, FR_WF'(0)}),
        .i_side  ({r6_tir, r6_leave, r6_c, r6_n}),
        .o_valid (sq2_v),
        .o_root  (ct),
        .o_side  (sq2_side)
    );

    assign {s3_tir, s3_leave, s3_c, s3_n} = sq2_side;

    // stage 7: index times cosine products
    logic [15:0] ei, et;
    assign ei = s3_leave ? s3_n : FR_IOR_ONE;
    assign et = s3_leave ? FR_IOR_ONE : s3_n;

    logic                 r7_v, r7_tir;
    logic [FR_PROD_W-1:0] r7_as, r7_bs, r7_ap, r7_bp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= sq2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_as  <= FR_PROD_W'(et) * FR_PROD_W'(s3_c);
            r7_bs  <= FR_PROD_W'(ei) * FR_PROD_W'(ct);
            r7_ap  <= FR_PROD_W'(ei) * FR_PROD_W'(s3_c);
            r7_bp  <= FR_PROD_W'(et) * FR_PROD_W'(ct);
            r7_tir <= s3_tir;
        end
    end

    // stage 8: |a - b| and a + b
    logic                 r8_v, r8_tir;
    logic [FR_PROD_W-1:0] r8_num_s, r8_den_s, r8_num_p, r8_den_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en) begin
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_num_s <= (r7_as >= r7_bs) ? r7_as - r7_bs : r7_bs - r7_as;
            r8_den_s <= r7_as + r7_bs;
            r8_num_p <= (r7_ap >= r7_bp) ? r7_ap - r7_bp : r7_bp - r7_ap;
            r8_den_p <= r7_ap + r7_bp;
            r8_tir   <= r7_tir;
        end
    end

    // stage 9: normalizing shift amounts
    logic                 r9_v, r9_tir;
    logic [FR_PROD_W-1:0] r9_num_s, r9_den_s, r9_num_p, r9_den_p;
    logic [FR_SH_W-1:0]   r9_sh_s, r9_sh_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (en) begin
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_num_s <= r8_num_s;
            r9_den_s <= r8_den_s;
            r9_num_p <= r8_num_p;
            r9_den_p <= r8_den_p;
            r9_sh_s  <= fr_norm_shift(r8_den_s);
            r9_sh_p  <= fr_norm_shift(r8_den_p);
            r9_tir   <= r8_tir;
        end
    end

    // stage 10: apply the shift
    logic [FR_PROD_W-1:0] n10_num_s, n10_den_s, n10_num_p, n10_den_p;
    assign n10_num_s = r9_num_s >> r9_sh_s;
    assign n10_den_s = r9_den_s >> r9_sh_s;
    assign n10_num_p = r9_num_p >> r9_sh_p;
    assign n10_den_p = r9_den_p >> r9_sh_p;

    logic                   r10_v, r10_tir;
    logic [FR_DEN_BITS-1:0] r10_num_s, r10_den_s, r10_num_p, r10_den_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else if (en) begin
            r10_v <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_num_s <= n10_num_s[FR_DEN_BITS-1:0];
            r10_den_s <= n10_den_s[FR_DEN_BITS-1:0];
            r10_num_p <= n10_num_p[FR_DEN_BITS-1:0];
            r10_den_p <= n10_den_p[FR_DEN_BITS-1:0];
            r10_tir   <= r9_tir;
        end
    end

    // amplitude ratios num * 2^30 / den; num <= den keeps the quotient in 31 bits
    logic             dvs_v, dvp_v, s4_tir, s4_tir_p;
    logic [FR_CW-1:0] q_s, q_p;

    fr_div_pipe #(.DW(FR_DEN_BITS), .QW(FR_CW), .SW(1)) u_div_rs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r10_v),
        .i_hi    ({1'b0, r10_num_s[FR_DEN_BITS-1:1]}),
        .i_lo    ({r10_num_s[0], FR_WF'(0)}),
        .i_den   (r10_den_s),
        .i_side  (r10_tir),
        .o_valid (dvs_v),
        .o_quot  (q_s),
        .o_side  (s4_tir)
    );

    fr_div_pipe #(.DW(FR_DEN_BITS), .QW(FR_CW), .SW(1)) u_div_rp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r10_v),
        .i_hi    ({1'b0, r10_num_p[FR_DEN_BITS-1:1]}),
        .i_lo    ({r10_num_p[0], FR_WF'(0)}),
        .i_den   (r10_den_p),
        .i_side  (r10_tir),
        .o_valid (dvp_v),
        .o_quot  (q_p),
        .o_side  (s4_tir_p)
    );

    // stage 11: cap at 1.0 (a zero denominator yields all ones and lands here)
    logic             r11_v, r11_tir;
    logic [FR_CW-1:0] r11_rs, r11_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_v <= 1'b0;
        end else if (en) begin
            r11_v <= dvs_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_rs  <= (q_s > FR_WONE) ? FR_WONE : q_s;
            r11_rp  <= (q_p > FR_WONE) ? FR_WONE : q_p;
            r11_tir <= s4_tir;
        end
    end

    // stage 12: squares
    logic [2*FR_CW-1:0] rs2_full, rp2_full;
    assign rs2_full = (2*FR_CW)'(r11_rs) * (2*FR_CW)'(r11_rs);
    assign rp2_full = (2*FR_CW)'(r11_rp) * (2*FR_CW)'(r11_rp);

    logic             r12_v, r12_tir;
    logic [FR_CW-1:0] r12_rs2, r12_rp2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_v <= 1'b0;
        end else if (en) begin
            r12_v <= r11_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r12_rs2 <= rs2_full[FR_WF +: FR_CW];
            r12_rp2 <= rp2_full[FR_WF +: FR_CW];
            r12_tir <= r11_tir;
        end
    end

    // stage 13: average, round to Q1.15, saturate; total reflection forces 1.0
    logic [FR_CW:0]   sum2;
    logic [FR_CW-1:0] avg;
    logic [FR_CW-1:0] rnd;
    logic [16:0]      q15;
    t_fr_out          n_out;

    assign sum2 = (FR_CW+1)'(r12_rs2) + (FR_CW+1)'(r12_rp2);
    assign avg  = sum2[FR_CW:1];
    assign rnd  = avg + (FR_CW'(1) << (FR_WF - 16));
    assign q15  = {1'b0, rnd[FR_CW-1 -: 16]};

    always_comb begin
        if (r12_tir) begin
            n_out.reflectance      = FR_OUT_ONE;
            n_out.total_reflection = 1'b1;
        end else begin
            n_out.reflectance      = (q15 > 17'(FR_OUT_ONE)) ? FR_OUT_ONE : q15[15:0];
            n_out.total_reflection = 1'b0;
        end
    end

    logic    r13_v;
    t_fr_out r13_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r13_v <= 1'b0;
        end else if (en) begin
            r13_v <= r12_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r13_out <= n_out;
        end
    end

    assign o_valid = r13_v;
    assign o_data  = r13_out;

    // the two ratio dividers run in lockstep
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dvs_v == dvp_v && (!dvs_v || s4_tir == s4_tir_p))
        else $error("ratio dividers out of step");

    a_tir_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.total_reflection |-> o_data.reflectance == FR_OUT_ONE)
        else $error("total reflection without full reflectance");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.reflectance <= FR_OUT_ONE)
        else $error("reflectance above one");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r1_v)
        else $error("pipeline not empty after reset");

endmodule
